### hw/rtl/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg: shared types and codes of the heartbeat membership table
// Holds the table entry type, command and status codes, register indexes and
// the control word that drives the row of table cells.
// ----------------------------------------------------------------------------
package hmt_pkg;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] hb;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_MERGE  = 3'd1,
    CMD_REPLY  = 3'd2,
    CMD_BEAT   = 3'd3,
    CMD_EXPORT = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_OWN_ID    = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_OWN_PORT  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_FAIL_TO   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_REMOVE_TO = 8'd3;

  // Control word broadcast to every cell.
  typedef struct packed {
    logic shift;  // take the right-hand neighbor's entry
    logic wr;     // the addressed cell takes the write data instead
  } cell_ctrl_t;

endpackage

### hw/rtl/hmt_if.sv
// ----------------------------------------------------------------------------
// hmt_if: channel interfaces of the heartbeat membership table
// Command channel, result channel and configuration write channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface hmt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] entry_id;
  logic [15:0] entry_port;
  logic [31:0] entry_heartbeat;
  logic [31:0] current_time;
  modport source (output valid, cmd, entry_id, entry_port, entry_heartbeat, current_time,
                  input ready);
  modport sink (input valid, cmd, entry_id, entry_port, entry_heartbeat, current_time,
                output ready);
endinterface

interface hmt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_id;
  logic [15:0] out_port;
  logic [31:0] out_heartbeat;
  logic [2:0]  status;
  logic        last_result;
  modport source (output valid, out_id, out_port, out_heartbeat, status, last_result,
                  input ready);
  modport sink (input valid, out_id, out_port, out_heartbeat, status, last_result,
                output ready);
endinterface

interface hmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/hmt_cell.sv
// ----------------------------------------------------------------------------
// hmt_cell: one slot of the membership table
// Holds one entry; each cycle it keeps it, takes its neighbor's entry, or
// takes the write data when it is the addressed cell.
// ----------------------------------------------------------------------------
module hmt_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                clk_i,
  input  hmt_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]     idx_i,
  input  hmt_pkg::entry_t     wr_data_i,
  input  hmt_pkg::entry_t     nbr_i,
  output hmt_pkg::entry_t     ent_o
);

  hmt_pkg::entry_t ent_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && (idx_i == CntW'(Idx))) begin
      ent_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      ent_q <= nbr_i;
    end
  end

  assign ent_o = ent_q;

endmodule

### hw/rtl/heartbeat_membership_table.sv
// ----------------------------------------------------------------------------
// heartbeat_membership_table: insertion-ordered gossip membership table
// Row of entry cells walked as a queue by a small command sequencer.
// ----------------------------------------------------------------------------
// The table lives in a row of TABLE_DEPTH cells that behave as a queue: the
// entry at the head cell is inspected, and every step the row shifts one
// place toward the head while the (possibly updated) entry is written back
// behind the last kept entry. Merge, reply, beat and export each walk all
// stored entries this way, then close the walk and hand the result word to
// the output register on the way back to idle; the result channel can stall
// both the walk and the hand-over. Init and unknown commands skip the walk
// and go straight to the hand-over of their single result word. Export
// deletes entries older than remove_timeout as they pass the head, which
// compacts the table in the same walk, and emits one result word per fresh
// entry; the word of an emitted entry is held back until the next one is
// found so that the final word can carry last_result. Only one command word
// is in work at a time; the command channel is ready again once the last
// result word has been moved to the output register. Configuration registers
// are written through their own channel, which is always ready, and should be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module heartbeat_membership_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  hmt_in_if.sink     in_i,
  hmt_out_if.source  out_o,
  hmt_cfg_if.sink    cfg_i
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_END,
    S_FIN
  } state_e;

  // Configuration registers.
  logic [31:0] own_id_q;
  logic [15:0] own_port_q;
  logic [15:0] fail_to_q;
  logic [15:0] remove_to_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      own_port_q  <= '0;
      fail_to_q   <= 16'd5;
      remove_to_q <= 16'd20;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        hmt_pkg::REG_OWN_ID:    own_id_q    <= cfg_i.data;
        hmt_pkg::REG_OWN_PORT:  own_port_q  <= cfg_i.data[15:0];
        hmt_pkg::REG_FAIL_TO:   fail_to_q   <= cfg_i.data[15:0];
        hmt_pkg::REG_REMOVE_TO: remove_to_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_e            state_q;
  hmt_pkg::cmd_e     cmd_q;
  logic [31:0]       id_q;
  logic [15:0]       port_q;
  logic [31:0]       hb_q;
  logic [31:0]       now_q;
  logic [CntW-1:0]   count_q;  // stored entries
  logic [CntW-1:0]   pos_q;    // original slot number of the head entry
  logic [CntW-1:0]   len_q;    // entries still in the queue during a walk
  logic              found_q;
  logic              pend_v_q;
  hmt_pkg::entry_t   pend_q;
  hmt_pkg::status_e  pend_st_q;
  logic              out_v_q;
  logic [31:0]       out_id_q;
  logic [15:0]       out_port_q;
  logic [31:0]       out_hb_q;
  hmt_pkg::status_e  out_st_q;
  logic              out_last_q;

  // Cell row.
  hmt_pkg::entry_t     cells [TABLE_DEPTH];
  hmt_pkg::entry_t     head;
  hmt_pkg::cell_ctrl_t ctrl;
  logic [CntW-1:0]     wr_idx;
  hmt_pkg::entry_t     wr_data;

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    hmt_pkg::entry_t nbr;
    if (j == TABLE_DEPTH - 1) begin : g_tail
      assign nbr = cells[j];
    end else begin : g_mid
      assign nbr = cells[j+1];
    end
    hmt_cell #(
      .CntW (CntW),
      .Idx  (j)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .idx_i     (wr_idx),
      .wr_data_i (wr_data),
      .nbr_i     (nbr),
      .ent_o     (cells[j])
    );
  end

  assign head = cells[0];

  logic            in_acc;
  logic            out_free;
  logic            out_load;
  logic            first;
  logic            eq;
  logic [31:0]     age;
  logic [31:0]     hb_inc;
  logic            hit;
  logic            drop;
  logic            emit;
  logic            stall;
  logic            walk_last;
  hmt_pkg::entry_t new_ent;
  hmt_pkg::status_e hit_st;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_v_q || out_o.ready;
  assign first      = (pos_q == '0);
  assign eq         = (head.id == id_q) && (head.port == port_q);
  assign age        = now_q - head.stamp;
  assign hb_inc     = (&head.hb) ? head.hb : head.hb + 32'd1;
  assign walk_last  = ((pos_q + CntW'(1)) == count_q);

  always_comb begin
    hit     = 1'b0;
    drop    = 1'b0;
    emit    = 1'b0;
    hit_st  = hmt_pkg::ST_UPDATED;
    new_ent = head;
    case (cmd_q)
      hmt_pkg::CMD_MERGE: begin
        hit = !found_q && eq;
        if (hit && (hb_q > head.hb)) begin
          new_ent.hb    = hb_q;
          new_ent.stamp = now_q;
        end else begin
          hit_st = hmt_pkg::ST_UNCHANGED;
        end
      end
      hmt_pkg::CMD_REPLY: begin
        hit = !found_q && !first && eq;
        if (hit) begin
          new_ent.hb    = hb_inc;
          new_ent.stamp = now_q;
        end
      end
      hmt_pkg::CMD_BEAT: begin
        hit = first;
        if (first && (count_q > CntW'(1))) begin
          new_ent.hb    = hb_inc;
          new_ent.stamp = now_q;
        end else begin
          hit_st = hmt_pkg::ST_UNCHANGED;
        end
      end
      hmt_pkg::CMD_EXPORT: begin
        // A deleted entry is never emitted, even when fail_timeout is larger.
        drop = !first && (age > {16'd0, remove_to_q});
        emit = first || (!drop && (age <= {16'd0, fail_to_q}));
      end
      default: ;
    endcase
  end

  // An emitted entry must push the held word out first; wait for room.
  assign stall = (state_q == S_WALK) && emit && pend_v_q && !out_free;

  // The output register takes a new word in either of these two cases.
  assign out_load = ((state_q == S_WALK) && !stall && emit && pend_v_q) ||
                    ((state_q == S_FIN) && out_free);

  always_comb begin
    ctrl    = '0;
    wr_idx  = '0;
    wr_data = head;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.cmd == hmt_pkg::CMD_INIT)) begin
          ctrl.wr = 1'b1;
          wr_data = '{id: own_id_q, port: own_port_q, hb: 32'd0,
                      stamp: in_i.current_time};
        end
      end
      S_WALK: begin
        if (!stall) begin
          ctrl.shift = 1'b1;
          ctrl.wr    = !drop;
          wr_idx     = len_q - CntW'(1);
          wr_data    = new_ent;
        end
      end
      S_END: begin
        if ((cmd_q == hmt_pkg::CMD_MERGE) && !found_q && (count_q < CntW'(TABLE_DEPTH))) begin
          ctrl.wr = 1'b1;
          wr_idx  = count_q;
          wr_data = '{id: id_q, port: port_q, hb: hb_q, stamp: now_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= hmt_pkg::CMD_INIT;
      count_q    <= '0;
      pos_q      <= '0;
      len_q      <= '0;
      found_q    <= 1'b0;
      pend_v_q   <= 1'b0;
      pend_st_q  <= hmt_pkg::ST_DONE;
      out_v_q    <= 1'b0;
      out_st_q   <= hmt_pkg::ST_DONE;
      out_last_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_o.ready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q    <= hmt_pkg::cmd_e'(in_i.cmd);
            id_q     <= in_i.entry_id;
            port_q   <= in_i.entry_port;
            hb_q     <= in_i.entry_heartbeat;
            now_q    <= in_i.current_time;
            pos_q    <= '0;
            len_q    <= count_q;
            found_q  <= 1'b0;
            pend_v_q <= 1'b0;
            case (in_i.cmd)
              hmt_pkg::CMD_INIT: begin
                count_q   <= CntW'(1);
                pend_q    <= '{id: own_id_q, port: own_port_q, hb: 32'd0,
                               stamp: in_i.current_time};
                pend_st_q <= hmt_pkg::ST_DONE;
                state_q   <= S_FIN;
              end
              hmt_pkg::CMD_MERGE, hmt_pkg::CMD_REPLY,
              hmt_pkg::CMD_BEAT, hmt_pkg::CMD_EXPORT: begin
                state_q <= (count_q == '0) ? S_END : S_WALK;
              end
              default: begin
                pend_q    <= '0;
                pend_st_q <= hmt_pkg::ST_DONE;
                state_q   <= S_FIN;
              end
            endcase
          end
        end
        S_WALK: begin
          if (!stall) begin
            pos_q <= pos_q + CntW'(1);
            if (drop) begin
              len_q <= len_q - CntW'(1);
            end
            if (hit) begin
              found_q   <= 1'b1;
              pend_v_q  <= 1'b1;
              pend_q    <= new_ent;
              pend_st_q <= hit_st;
            end
            if (emit) begin
              if (pend_v_q) begin
                out_id_q   <= pend_q.id;
                out_port_q <= pend_q.port;
                out_hb_q   <= pend_q.hb;
                out_st_q   <= pend_st_q;
                out_last_q <= 1'b0;
              end
              pend_v_q  <= 1'b1;
              pend_q    <= head;
              pend_st_q <= hmt_pkg::ST_DONE;
            end
            if (walk_last) begin
              state_q <= S_END;
            end
          end
        end
        S_END: begin
          state_q <= S_FIN;
          case (cmd_q)
            hmt_pkg::CMD_MERGE: begin
              if (!found_q) begin
                pend_q <= '{id: id_q, port: port_q, hb: hb_q, stamp: now_q};
                if (count_q < CntW'(TABLE_DEPTH)) begin
                  count_q   <= count_q + CntW'(1);
                  pend_st_q <= hmt_pkg::ST_INSERTED;
                end else begin
                  pend_st_q <= hmt_pkg::ST_FULL;
                end
              end
            end
            hmt_pkg::CMD_REPLY: begin
              if (!found_q) begin
                pend_q    <= '{id: id_q, port: port_q, hb: 32'd0, stamp: now_q};
                pend_st_q <= hmt_pkg::ST_NOT_FOUND;
              end
            end
            hmt_pkg::CMD_BEAT: begin
              if (!found_q) begin
                pend_q    <= '0;
                pend_st_q <= hmt_pkg::ST_NOT_FOUND;
              end
            end
            hmt_pkg::CMD_EXPORT: begin
              count_q <= len_q;
              if (!pend_v_q) begin
                pend_q    <= '0;
                pend_st_q <= hmt_pkg::ST_DONE;
              end
            end
            default: ;
          endcase
        end
        S_FIN: begin
          if (out_free) begin
            out_id_q   <= pend_q.id;
            out_port_q <= pend_q.port;
            out_hb_q   <= pend_q.hb;
            out_st_q   <= pend_st_q;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.out_id        = out_id_q;
  assign out_o.out_port      = out_port_q;
  assign out_o.out_heartbeat = out_hb_q;
  assign out_o.status        = out_st_q;
  assign out_o.last_result   = out_last_q;

endmodule

### hw/rtl/hmt_checker.sv
// ----------------------------------------------------------------------------
// hmt_checker: port-level assertions for the heartbeat membership table
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module hmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_id_i,
  input logic [2:0]  out_status_i,
  input logic        out_last_i
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_id_i) && $stable(out_status_i)
  ) else $error("stalled result word changed");

  // One command word at a time: after acceptance the command channel closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i
  ) else $error("command accepted while another is in work");

  // Only export words that are not the final one come without last_result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == hmt_pkg::ST_DONE
  ) else $error("non-final result word with a status other than done");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= hmt_pkg::ST_NOT_FOUND
  ) else $error("undefined status code");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_id_i     (out_o.out_id),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last_result)
);
